// File: hdl/clmd_pkg.sv
`timescale 1ns / 1ps
// Package for the Content-Length message deframer: phase and number-parser
// types, character codes and the header-name literal table.
// No dependencies.
package clmd_pkg;

  // Width of the length accumulator and of the body countdown
  localparam int LENGTH_BITS = 32;
  localparam int NAME_LEN    = 16;
  localparam int POS_BITS    = 5;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parser phase; the two unused codes behave as PH_MATCH
  typedef enum logic [2:0] {
    PH_MATCH  = 3'd0,
    PH_SKIP   = 3'd1,
    PH_NUMBER = 3'd2,
    PH_DROP   = 3'd3,
    PH_TERM   = 3'd4,
    PH_BODY   = 3'd5
  } phase_t;

  // Decimal length parser state
  typedef enum logic [1:0] {
    NUM_BEFORE = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_t;

  // Header name "Content-Length: " one character per position
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = " ";
    endcase
    return c;
  endfunction

  // Whitespace skipped ahead of the first length digit
  function automatic logic is_lead_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_VT) || (b == CH_FF);
  endfunction

endpackage

// File: hdl/content_length_message_deframer_top.sv
`timescale 1ns / 1ps
// A result is registered after its byte is accepted (input register, then
// result register); a stall can hold the byte in the input register between.
// Throughput: one byte per cycle unless the output stalls; the parser state
// is updated from the registered byte as its result is registered.
// The input register lets one more byte in while a result waits.
// Reset (rst_n low, synchronous): pipeline empty, parser back to matching
// the header name with length and counters cleared.
// Content-Length message deframer, single module.
// Depends on clmd_pkg.
module content_length_message_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_is_body,
  output logic        out_message_end,
  output logic [31:0] out_body_length,
  output logic        out_header_rejected
);
  import clmd_pkg::*;

  localparam int WIDE_BITS = LENGTH_BITS + 4;

  // Pipeline registers
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic [7:0] out_data_byte_r;
  logic       out_is_body_r;
  logic       out_message_end_r;
  logic [31:0] out_body_length_r;
  logic       out_header_rejected_r;

  // Parser state
  phase_t               phase_r, phase_nxt;
  logic [POS_BITS-1:0]  match_pos_r, match_pos_nxt;
  logic                 skip_cr_r, skip_cr_nxt;
  num_t                 num_r, num_nxt;
  logic [LENGTH_BITS-1:0] accum_r, accum_nxt;
  logic [1:0]           term_depth_r, term_depth_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;

  // Per-item flags
  logic       is_body;
  logic       msg_end;
  logic       rejected;
  logic [LENGTH_BITS-1:0] shown;

  logic       advance;
  logic       fire;
  logic [7:0] b;
  logic       is_digit;
  logic [WIDE_BITS-1:0] accum_wide;
  logic [WIDE_BITS-1:0] accum_x10;
  logic       accum_ovf;
  logic [POS_BITS-1:0] pos_clamped;
  logic [LENGTH_BITS-1:0] remain_dec;

  // Handshake
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign fire     = in_valid_r && advance;
  assign b        = in_byte_r;

  // Decimal step: accum * 10 + digit, saturation on carry beyond the width
  assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
  assign accum_wide = WIDE_BITS'(accum_r);
  assign accum_x10  = (accum_wide << 3) + (accum_wide << 1) + WIDE_BITS'(b - CH_ZERO);
  assign accum_ovf  = |accum_x10[WIDE_BITS-1:LENGTH_BITS];

  assign pos_clamped = (match_pos_r > POS_BITS'(NAME_LEN - 1)) ? '0 : match_pos_r;
  assign remain_dec  = (remain_r != '0) ? remain_r - LENGTH_BITS'(1) : remain_r;

  // Output flags per phase
  always_comb begin
    is_body  = 1'b0;
    msg_end  = 1'b0;
    rejected = 1'b0;
    case (phase_r)
      PH_SKIP, PH_NUMBER, PH_DROP: begin
      end
      PH_TERM: begin
        msg_end = (term_depth_r == 2'd3) && (b == CH_LF) && (accum_r == '0);
      end
      PH_BODY: begin
        is_body = 1'b1;
        msg_end = (remain_dec == '0);
      end
      default: begin
        rejected = (b != name_char(pos_clamped[3:0]));
      end
    endcase
  end

  // Next parser state
  always_comb begin
    phase_nxt      = phase_r;
    match_pos_nxt  = match_pos_r;
    skip_cr_nxt    = skip_cr_r;
    num_nxt        = num_r;
    accum_nxt      = accum_r;
    term_depth_nxt = term_depth_r;
    remain_nxt     = remain_r;
    case (phase_r)
      PH_SKIP: begin
        if (skip_cr_r && (b == CH_LF)) begin
          phase_nxt     = PH_MATCH;
          match_pos_nxt = '0;
          skip_cr_nxt   = 1'b0;
        end else begin
          skip_cr_nxt = (b == CH_CR);
        end
      end
      PH_NUMBER: begin
        if (b == CH_CR) begin
          phase_nxt = PH_DROP;
        end else if (num_r != NUM_DONE) begin
          if (is_digit) begin
            num_nxt   = NUM_DIGITS;
            accum_nxt = accum_ovf ? '1 : accum_x10[LENGTH_BITS-1:0];
          end else if (!((num_r == NUM_BEFORE) && is_lead_space(b))) begin
            num_nxt = NUM_DONE;
          end
        end
      end
      PH_DROP: begin
        term_depth_nxt = 2'd2;
        phase_nxt      = PH_TERM;
      end
      PH_TERM: begin
        case (term_depth_r)
          2'd0, 2'd2: term_depth_nxt = (b == CH_CR) ? term_depth_r + 2'd1 : 2'd0;
          2'd1:       term_depth_nxt = (b == CH_LF) ? 2'd2 : 2'd0;
          default: begin
            term_depth_nxt = 2'd0;
            if (b == CH_LF) begin
              if (accum_r == '0) begin
                phase_nxt     = PH_MATCH;
                match_pos_nxt = '0;
              end else begin
                remain_nxt = accum_r;
                phase_nxt  = PH_BODY;
              end
            end
          end
        endcase
      end
      PH_BODY: begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt     = PH_MATCH;
          match_pos_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_MATCH;
        if (!rejected) begin
          if (pos_clamped == POS_BITS'(NAME_LEN - 1)) begin
            match_pos_nxt = '0;
            phase_nxt     = PH_NUMBER;
            num_nxt       = NUM_BEFORE;
            accum_nxt     = '0;
          end else begin
            match_pos_nxt = pos_clamped + POS_BITS'(1);
          end
        end else begin
          match_pos_nxt = '0;
          skip_cr_nxt   = 1'b0;
          phase_nxt     = PH_SKIP;
        end
      end
    endcase
    // Length shown with this byte, then cleared at the end of a message
    shown = accum_nxt;
    if (msg_end) begin
      accum_nxt = '0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_MATCH;
      match_pos_r  <= '0;
      skip_cr_r    <= 1'b0;
      num_r        <= NUM_BEFORE;
      accum_r      <= '0;
      term_depth_r <= 2'd0;
      remain_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        phase_r      <= phase_nxt;
        match_pos_r  <= match_pos_nxt;
        skip_cr_r    <= skip_cr_nxt;
        num_r        <= num_nxt;
        accum_r      <= accum_nxt;
        term_depth_r <= term_depth_nxt;
        remain_r     <= remain_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
    if (fire) begin
      out_data_byte_r       <= b;
      out_is_body_r         <= is_body;
      out_message_end_r     <= msg_end;
      out_body_length_r     <= 32'(shown);
      out_header_rejected_r <= rejected;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data_byte       = out_data_byte_r;
  assign out_is_body         = out_is_body_r;
  assign out_message_end     = out_message_end_r;
  assign out_body_length     = out_body_length_r;
  assign out_header_rejected = out_header_rejected_r;

`ifndef SYNTH
  // A body byte is never a header rejection
  a_body_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_body |-> !out_header_rejected)
    else $error("body byte flagged as rejected");

  // An end outside the body is the final LF of the headers
  a_header_end_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end && !out_is_body |-> out_data_byte == CH_LF)
    else $error("header end on a byte other than LF");

  // Name matching always runs with a cleared length
  a_reject_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_rejected |-> out_body_length == 32'd0)
    else $error("rejection with a non-zero length");

  // The body phase always has bytes left to pass
  a_body_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> remain_r != '0)
    else $error("body phase with nothing remaining");

  // A stalled byte in the input register is held
  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r))
    else $error("input register lost a stalled byte");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for content_length_message_deframer_top: sends framed
// messages, noise and broken headers, and checks each result against a predictor.
// Depends on clmd_pkg and the deframer RTL.
module tb;
  import clmd_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 5;
  localparam int LONG_HOLD    = 60;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 540;
  localparam logic [127:0] HDR_NAME = "Content-Length: ";
  localparam logic [31:0]  LEN_MAX  = '1;

  // One expected result item
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_body;
    logic        message_end;
    logic [31:0] body_length;
    logic        header_rejected;
  } deframe_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_data_byte;
  logic        out_is_body;
  logic        out_message_end;
  logic [31:0] out_body_length;
  logic        out_header_rejected;

  content_length_message_deframer_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_byte       (out_data_byte),
    .out_is_body         (out_is_body),
    .out_message_end     (out_message_end),
    .out_body_length     (out_body_length),
    .out_header_rejected (out_header_rejected)
  );

  // Parser state as the testbench sees it
  phase_t      prs_phase;
  logic [4:0]  name_idx;
  logic        skip_cr_seen;
  num_t        len_state;
  logic [31:0] len_value;
  logic [1:0]  crlf_depth;
  logic [31:0] bytes_left;

  deframe_res_t pending_results[$];

  int  fails;
  int  bytes_in;
  int  frames_done;
  int  rejects_seen;
  int  body_seen;
  int  idle_cycles;
  int  quiet_left;
  int  holds_asked;
  int  holds_served;
  bit  idle_on;

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  function automatic logic [7:0] hdr_char(input int pos);
    return HDR_NAME[8*(15-pos) +: 8];
  endfunction

  // Advance the predicted parser by one byte and return its result
  function automatic deframe_res_t deframe_byte(input logic [7:0] b);
    deframe_res_t r;
    logic [31:0]  digit;
    r = '0;
    r.data_byte = b;
    case (prs_phase)
      PH_SKIP: begin
        if (skip_cr_seen && b == CH_LF) begin
          prs_phase    = PH_MATCH;
          name_idx     = '0;
          skip_cr_seen = 1'b0;
        end else begin
          skip_cr_seen = (b == CH_CR);
        end
      end
      PH_NUMBER: begin
        if (b == CH_CR) begin
          prs_phase = PH_DROP;
        end else if (len_state != NUM_DONE) begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            digit     = {24'd0, b - CH_ZERO};
            len_state = NUM_DIGITS;
            if (len_value > (LEN_MAX - digit) / 10)
              len_value = LEN_MAX;
            else
              len_value = len_value * 10 + digit;
          end else if (!(len_state == NUM_BEFORE &&
                         (b == CH_SPACE || b == CH_TAB || b == CH_LF ||
                          b == CH_VT || b == CH_FF))) begin
            len_state = NUM_DONE;
          end
        end
      end
      PH_DROP: begin
        // byte after the length CR is thrown away; search resumes after CR LF
        crlf_depth = 2'd2;
        prs_phase  = PH_TERM;
      end
      PH_TERM: begin
        if (crlf_depth == 2'd0 || crlf_depth == 2'd2) begin
          crlf_depth = (b == CH_CR) ? crlf_depth + 2'd1 : 2'd0;
        end else if (crlf_depth == 2'd1) begin
          crlf_depth = (b == CH_LF) ? 2'd2 : 2'd0;
        end else begin
          crlf_depth = 2'd0;
          if (b == CH_LF) begin
            if (len_value == 0) begin
              r.message_end = 1'b1;
              prs_phase     = PH_MATCH;
              name_idx      = '0;
            end else begin
              bytes_left = len_value;
              prs_phase  = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        r.is_body = 1'b1;
        if (bytes_left != 0) bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          r.message_end = 1'b1;
          prs_phase     = PH_MATCH;
          name_idx      = '0;
        end
      end
      default: begin
        prs_phase = PH_MATCH;
        if (name_idx > 5'd15) name_idx = '0;
        if (b == hdr_char(int'(name_idx[3:0]))) begin
          name_idx = name_idx + 5'd1;
          if (name_idx >= 5'd16) begin
            name_idx  = '0;
            prs_phase = PH_NUMBER;
            len_state = NUM_BEFORE;
            len_value = '0;
          end
        end else begin
          r.header_rejected = 1'b1;
          name_idx          = '0;
          skip_cr_seen      = 1'b0;
          prs_phase         = PH_SKIP;
        end
      end
    endcase
    r.body_length = len_value;
    if (r.message_end) len_value = '0;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      fails++;
    end
  endtask

  // Predict on each accepted byte, check each accepted result, watch for hangs
  always @(posedge clk) begin : result_check
    deframe_res_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(deframe_byte(in_byte));
        bytes_in++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result item with no byte outstanding: data_byte %0h", out_data_byte);
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
          check_field("is_body", 32'(want.is_body), 32'(out_is_body));
          check_field("message_end", 32'(want.message_end), 32'(out_message_end));
          check_field("body_length", want.body_length, out_body_length);
          check_field("header_rejected", 32'(want.header_rejected),
                      32'(out_header_rejected));
        end
        if (out_message_end === 1'b1) frames_done++;
        if (out_header_rejected === 1'b1) rejects_seen++;
        if (out_is_body === 1'b1) body_seen++;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, quiet stretches and long hold-offs on request
  initial begin : receiver
    int k;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_served++;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        k = $urandom_range(1, 4);
        repeat (k - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 19) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one byte and hold it until it is taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (idle_on && quiet_left == 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end else if (quiet_left != 0) begin
      quiet_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(10, 40);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Optional noise, then one frame with random length text, headers and body
  task automatic send_random_message();
    int         n_len;
    int         k;
    int         i;
    logic [7:0] b;
    logic [7:0] prev;
    if ($urandom_range(0, 4) == 0) begin
      // broken name: a prefix, a wrong byte, junk, then CR LF to resync
      k = $urandom_range(0, 15);
      for (i = 0; i < k; i++) send_byte(hdr_char(i));
      do b = 8'($urandom_range(0, 255)); while (b == hdr_char(k));
      send_byte(b);
      prev = 8'h00;
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (prev == CH_CR && b == CH_LF) b = CH_CR;
        send_byte(b);
        prev = b;
      end
      send_byte(CH_CR);
      send_byte(CH_LF);
    end
    for (i = 0; i < 16; i++) send_byte(hdr_char(i));
    // length text
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
      case ($urandom_range(0, 4))
        0: send_byte(CH_SPACE);
        1: send_byte(CH_TAB);
        2: send_byte(CH_LF);
        3: send_byte(CH_VT);
        default: send_byte(CH_FF);
      endcase
    end
    n_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(0, 16);
    if ($urandom_range(0, 9) == 0) begin
      n_len = 0;
    end else begin
      if ($urandom_range(0, 4) == 0) send_byte(CH_ZERO);
      send_text($sformatf("%0d", n_len));
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_CR || (b >= CH_ZERO && b <= CH_NINE));
        send_byte(b);
      end
    end
    send_byte(CH_CR);
    send_byte(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : CH_LF);
    // further header lines
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 8)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        send_byte(b);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_byte(CH_CR);
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        send_byte(b);
      end
      send_byte(CH_CR);
      send_byte(CH_LF);
    end
    send_byte(CH_CR);
    send_byte(CH_LF);
    // body, with the byte extremes now and then
    repeat (n_len) begin
      case ($urandom_range(0, 7))
        0: send_byte(8'h00);
        1: send_byte(8'hFF);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Rejected CR, LF that does not end the skip, CR CR LF re-arming it
  task automatic test_resync();
    send_text("\015\012ab\015\015\012");
  endtask

  // Plain frame with a header line and extreme body bytes; zero-length frame
  task automatic test_basic_frames();
    send_text("Content-Length: 3\015\012X-A: b\015\012\015\012");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_text("Content-Length: 0\015\012\015\012");
  endtask

  // Leading blanks, junk after digits, odd dropped byte, no digits, bad name
  task automatic test_length_text();
    send_text("Content-Length:  \011\012\013\01407x9\015Q\015\012");
    send_text("body!!!");
    send_text("Content-Length: abc\015\012\015\012");
    send_text("Content-Lx\015\012");
  endtask

  // Terminator search with stray CR and LF bytes in the headers
  task automatic test_terminator();
    send_text("Content-Length: 1\015\012H\015q\012\015\012\015\015\012\015\012\015\012Z");
  endtask

  task automatic test_random_traffic();
    int start;
    start = bytes_in;
    while (bytes_in - start < RANDOM_BYTES) send_random_message();
  endtask

  // Receiver holds off while a long frame keeps coming
  task automatic test_backpressure();
    int i;
    holds_asked++;
    send_text("Content-Length: 100\015\012\015\012");
    for (i = 0; i < 100; i++) send_byte(8'(i * 37));
  endtask

  // Length past the top of the range; left in the body at the end of the run
  task automatic test_saturation();
    send_text("Content-Length: 42949672967\015\012\015\012");
    repeat (40) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    idle_on      = 1'b1;
    fails        = 0;
    bytes_in     = 0;
    frames_done  = 0;
    rejects_seen = 0;
    body_seen    = 0;
    idle_cycles  = 0;
    quiet_left   = 0;
    holds_asked  = 0;
    holds_served = 0;
    prs_phase    = PH_MATCH;
    name_idx     = '0;
    skip_cr_seen = 1'b0;
    len_state    = NUM_BEFORE;
    len_value    = '0;
    crlf_depth   = '0;
    bytes_left   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_resync();
    test_basic_frames();
    test_length_text();
    test_terminator();
    test_random_traffic();
    // no idling from here on
    idle_on = 1'b0;
    test_backpressure();
    test_saturation();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes: %0d frames ended, %0d header rejections, %0d body bytes",
             bytes_in, frames_done, rejects_seen, body_seen);
    $display("Covered resync, length parsing, saturation and a long receiver hold-off");
    if (fails == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
